>>> hdl/tcw_pkg.sv
// Shared constants and codes for the text console writer.
// Used by tcw_screen_mem, text_console_writer and the test benches; no dependencies.
package tcw_pkg;

    localparam int CELL_W       = 16;
    localparam int CURSOR_PITCH = 80;
    localparam int HIDDEN_POS   = 8'hFF;

    localparam logic [15:0] HIDDEN_REG = 16'(HIDDEN_POS * CURSOR_PITCH + HIDDEN_POS);
    localparam logic [7:0]  BLANK_CHAR   = 8'h20;
    localparam logic [7:0]  NEWLINE_CHAR = 8'h0A;
    localparam logic [7:0]  RESET_ATTR   = 8'h07;

    localparam logic [1:0] OP_PUT_CHAR = 2'd0;
    localparam logic [1:0] OP_WRITE_AT = 2'd1;
    localparam logic [1:0] OP_CLEAR    = 2'd2;
    localparam logic [1:0] OP_READ_AT  = 2'd3;

    localparam logic CFG_TEXT_COLOR   = 1'b0;
    localparam logic CFG_CURSOR_SHOWN = 1'b1;

endpackage

>>> hdl/tcw_screen_mem.sv
// Screen cell store: one write port, one registered read port.
// Depends on tcw_pkg for the cell width.
module tcw_screen_mem
    import tcw_pkg::*;
#(
    parameter int DEPTH = 2000,
    parameter int AW    = 11
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [AW-1:0]     i_waddr,
    input  logic [CELL_W-1:0] i_wdata,
    input  logic [AW-1:0]     i_raddr,
    output logic [CELL_W-1:0] o_rdata
);

    logic [CELL_W-1:0] r_mem [DEPTH];
    logic [CELL_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> hdl/text_console_writer.sv
// Text console writer top level: cursor sequencer, sweep engine and result register.
// Depends on tcw_pkg and tcw_screen_mem.
// Put character and write cell pass through S_EXEC and S_DONE; read cell also goes
// through S_RDWAIT. A new item is taken only once the last result is registered.
// Clear and a scroll add a one-cell-per-cycle sweep over the store.
// Reset: synchronous; the store is then blanked before the first item is accepted.
module text_console_writer
    import tcw_pkg::*;
#(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,  // char_code[7:0], attr[15:8], row_sel[20:16],
                                       // col_sel[27:21], zero[31:28]
    input  logic [1:0]  s_axis_tuser,  // op[1:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata,  // cursor_row[4:0], cursor_col[11:5],
                                       // cursor_reg[27:12], cell_data[43:28], zero[47:44]
    input  logic        i_cfg_we,
    input  logic        i_cfg_index,
    input  logic [7:0]  i_cfg_data
);

    localparam int CELLS = ROWS * COLUMNS;
    localparam int AW    = $clog2(CELLS);
    localparam int RW    = $clog2(ROWS);
    localparam int CW    = $clog2(COLUMNS);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_EXEC   = 3'd1;
    localparam logic [2:0] S_RDWAIT = 3'd2;
    localparam logic [2:0] S_SHIFT  = 3'd3;
    localparam logic [2:0] S_FILL   = 3'd4;
    localparam logic [2:0] S_DONE   = 3'd5;

    logic [2:0]        r_state, n_state;
    logic [1:0]        r_op, n_op;
    logic [7:0]        r_ch, n_ch;
    logic [7:0]        r_at, n_at;
    logic              r_inside, n_inside;
    logic [AW-1:0]     r_addr, n_addr;
    logic [AW:0]       r_src, n_src;
    logic              r_pend, n_pend;
    logic              r_init, n_init;
    logic [RW-1:0]     r_cur_row, n_cur_row;
    logic [CW-1:0]     r_cur_col, n_cur_col;
    logic [15:0]       r_cell, n_cell;
    logic              r_out_valid, n_out_valid;
    logic [47:0]       r_out_data, n_out_data;
    logic [7:0]        r_text_color;
    logic              r_cursor_shown;

    logic              w_we;
    logic [AW-1:0]     w_addr;
    logic [CELL_W-1:0] w_data;
    logic [AW-1:0]     rd_addr;
    logic [CELL_W-1:0] rd_data;

    logic [1:0]        in_op;
    logic [7:0]        in_ch;
    logic [7:0]        in_at;
    logic [4:0]        in_row;
    logic [6:0]        in_col;
    logic [31:0]       a_row;
    logic [31:0]       a_col;
    logic              accept;
    logic              src_live;
    logic              wrap;
    logic [7:0]        fill_attr;
    logic [15:0]       cursor_reg;

    assign in_op  = s_axis_tuser;
    assign in_ch  = s_axis_tdata[7:0];
    assign in_at  = s_axis_tdata[15:8];
    assign in_row = s_axis_tdata[20:16];
    assign in_col = s_axis_tdata[27:21];

    assign s_axis_tready = (r_state == S_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    assign a_row     = (in_op == OP_PUT_CHAR) ? 32'(r_cur_row) : 32'(in_row);
    assign a_col     = (in_op == OP_PUT_CHAR) ? 32'(r_cur_col) : 32'(in_col);
    assign src_live  = (r_src < (AW+1)'(CELLS));
    assign wrap      = (r_ch == NEWLINE_CHAR) || (r_cur_col == CW'(COLUMNS - 1));
    assign fill_attr = r_init ? RESET_ATTR : r_text_color;
    assign cursor_reg = r_cursor_shown
                      ? 16'(32'(r_cur_row) * CURSOR_PITCH + 32'(r_cur_col))
                      : HIDDEN_REG;

    tcw_screen_mem #(
        .DEPTH (CELLS),
        .AW    (AW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_addr),
        .i_wdata (w_data),
        .i_raddr (rd_addr),
        .o_rdata (rd_data)
    );

    always_comb begin
        n_state     = r_state;
        n_op        = r_op;
        n_ch        = r_ch;
        n_at        = r_at;
        n_inside    = r_inside;
        n_addr      = r_addr;
        n_src       = r_src;
        n_pend      = r_pend;
        n_init      = r_init;
        n_cur_row   = r_cur_row;
        n_cur_col   = r_cur_col;
        n_cell      = r_cell;
        n_out_valid = r_out_valid && !m_axis_tready;
        n_out_data  = r_out_data;
        w_we        = 1'b0;
        w_addr      = r_addr;
        w_data      = {fill_attr, BLANK_CHAR};
        rd_addr     = r_addr;

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_op     = in_op;
                    n_ch     = in_ch;
                    n_at     = in_at;
                    n_inside = (32'(in_row) < ROWS) && (32'(in_col) < COLUMNS);
                    n_addr   = AW'(a_row * COLUMNS + a_col);
                    n_cell   = '0;
                    n_state  = S_EXEC;
                end
            end
            S_EXEC: begin
                n_state = S_DONE;
                unique case (r_op)
                    OP_PUT_CHAR: begin
                        w_we   = (r_ch != NEWLINE_CHAR);
                        w_data = {r_text_color, r_ch};
                        if (!wrap) begin
                            n_cur_col = r_cur_col + 1'b1;
                        end else begin
                            n_cur_col = '0;
                            if (r_cur_row == RW'(ROWS - 1)) begin
                                n_src   = (AW+1)'(COLUMNS);
                                n_pend  = 1'b0;
                                n_addr  = '0;
                                n_state = S_SHIFT;
                            end else begin
                                n_cur_row = r_cur_row + 1'b1;
                            end
                        end
                    end
                    OP_WRITE_AT: begin
                        w_we   = r_inside;
                        w_data = {r_at, r_ch};
                    end
                    OP_CLEAR: begin
                        n_cur_row = '0;
                        n_cur_col = '0;
                        n_addr    = '0;
                        n_state   = S_FILL;
                    end
                    OP_READ_AT: begin
                        n_state = S_RDWAIT;
                    end
                    default: begin
                        n_state = S_DONE;
                    end
                endcase
            end
            S_RDWAIT: begin
                n_cell  = r_inside ? rd_data : '0;
                n_state = S_DONE;
            end
            S_SHIFT: begin
                rd_addr = r_src[AW-1:0];
                w_we    = r_pend;
                w_data  = rd_data;
                n_pend  = src_live;
                if (src_live) begin
                    n_src = r_src + 1'b1;
                end
                if (r_pend) begin
                    n_addr = r_addr + 1'b1;
                end
                if (!src_live && !r_pend) begin
                    n_state = S_FILL;
                end
            end
            S_FILL: begin
                w_we = 1'b1;
                if (r_addr == AW'(CELLS - 1)) begin
                    n_init  = 1'b0;
                    n_state = r_init ? S_IDLE : S_DONE;
                end else begin
                    n_addr = r_addr + 1'b1;
                end
            end
            S_DONE: begin
                if (!r_out_valid || m_axis_tready) begin
                    n_out_valid = 1'b1;
                    n_out_data  = {4'b0, r_cell, cursor_reg, 7'(r_cur_col), 5'(r_cur_row)};
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_FILL;
            r_init      <= 1'b1;
            r_addr      <= '0;
            r_src       <= '0;
            r_pend      <= 1'b0;
            r_cur_row   <= '0;
            r_cur_col   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_init      <= n_init;
            r_addr      <= n_addr;
            r_src       <= n_src;
            r_pend      <= n_pend;
            r_cur_row   <= n_cur_row;
            r_cur_col   <= n_cur_col;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op       <= n_op;
        r_ch       <= n_ch;
        r_at       <= n_at;
        r_inside   <= n_inside;
        r_cell     <= n_cell;
        r_out_data <= n_out_data;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_text_color   <= RESET_ATTR;
            r_cursor_shown <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_TEXT_COLOR:   r_text_color   <= i_cfg_data;
                CFG_CURSOR_SHOWN: r_cursor_shown <= i_cfg_data[0];
                default:          r_text_color   <= r_text_color;
            endcase
        end
    end

    a_no_accept_in_init: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tready |-> !r_init)
        else $error("item accepted during reset blanking");

    a_cursor_on_screen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (32'(r_cur_row) < ROWS) && (32'(r_cur_col) < COLUMNS))
        else $error("cursor left the screen");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("ready held across an accepted item");

    a_scroll_copy_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SHIFT && r_pend) |-> (32'(r_addr) < CELLS - COLUMNS))
        else $error("scroll copy wrote into the bottom row");

endmodule

>>> test/tcw_console_checker.sv
// Watches the item, report and register channels of text_console_writer and scores every report.
// Keeps its own copy of the screen, cursor and registers to work out the expected reports.
// Depends on tcw_pkg.
module tcw_console_checker
    import tcw_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,  // char_code[7:0], attr[15:8], row_sel[20:16],
                                       // col_sel[27:21], zero[31:28]
    input  logic [1:0]  s_axis_tuser,  // op[1:0]
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [47:0] m_axis_tdata,  // cursor_row[4:0], cursor_col[11:5],
                                       // cursor_reg[27:12], cell_data[43:28], zero[47:44]
    input  logic        i_cfg_we,
    input  logic        i_cfg_index,
    input  logic [7:0]  i_cfg_data,
    output int          o_error_count,
    output int          o_pending,
    output int          o_items,
    output int          o_reports,
    output int          o_scrolls
);

    localparam int SCREEN_COLS   = 80;
    localparam int SCREEN_ROWS   = 25;
    localparam int SCREEN_CELLS  = SCREEN_COLS * SCREEN_ROWS;
    localparam int MAX_REPORTED  = 10;

    typedef struct {
        logic [4:0]  row;
        logic [6:0]  col;
        logic [15:0] creg;
        logic [15:0] cell_data;
    } t_console_report;

    logic [15:0]     shadow_screen [SCREEN_CELLS];
    int              shadow_row;
    int              shadow_col;
    logic [7:0]      shadow_color;
    logic            shadow_shown;
    t_console_report awaited_reports [$];

    int error_count  = 0;
    int pending      = 0;
    int item_count   = 0;
    int report_count = 0;
    int scroll_count = 0;

    assign o_error_count = error_count;
    assign o_pending     = pending;
    assign o_items       = item_count;
    assign o_reports     = report_count;
    assign o_scrolls     = scroll_count;

    function automatic void fill_from_row(int first, logic [15:0] fill_word);
        for (int i = first * SCREEN_COLS; i < SCREEN_CELLS; i++) begin
            shadow_screen[i] = fill_word;
        end
    endfunction

    function automatic void next_line();
        shadow_col = 0;
        shadow_row++;
        if (shadow_row >= SCREEN_ROWS) begin
            for (int i = 0; i < SCREEN_CELLS - SCREEN_COLS; i++) begin
                shadow_screen[i] = shadow_screen[i + SCREEN_COLS];
            end
            fill_from_row(SCREEN_ROWS - 1, {shadow_color, BLANK_CHAR});
            shadow_row = SCREEN_ROWS - 1;
            scroll_count++;
        end
    endfunction

    function automatic t_console_report advance_console(logic [1:0] op, logic [7:0] ch,
                                                        logic [7:0] at, logic [4:0] r,
                                                        logic [6:0] c);
        t_console_report rep;
        logic            on_screen;
        on_screen     = (r < SCREEN_ROWS) && (c < SCREEN_COLS);
        rep.cell_data = '0;
        case (op)
            OP_PUT_CHAR: begin
                if (ch == NEWLINE_CHAR) begin
                    next_line();
                end else begin
                    shadow_screen[shadow_row * SCREEN_COLS + shadow_col] = {shadow_color, ch};
                    shadow_col++;
                    if (shadow_col >= SCREEN_COLS) begin
                        next_line();
                    end
                end
            end
            OP_WRITE_AT: begin
                if (on_screen) begin
                    shadow_screen[r * SCREEN_COLS + c] = {at, ch};
                end
            end
            OP_CLEAR: begin
                fill_from_row(0, {shadow_color, BLANK_CHAR});
                shadow_row = 0;
                shadow_col = 0;
            end
            OP_READ_AT: begin
                if (on_screen) begin
                    rep.cell_data = shadow_screen[r * SCREEN_COLS + c];
                end
            end
        endcase
        rep.row  = 5'(shadow_row);
        rep.col  = 7'(shadow_col);
        rep.creg = shadow_shown ? 16'(shadow_row * CURSOR_PITCH + shadow_col) : HIDDEN_REG;
        return rep;
    endfunction

    function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
        if (got !== want) begin
            error_count++;
            if (error_count <= MAX_REPORTED) begin
                $display("Mismatch in %s of report %0d at %0t: expected %0h, got %0h",
                         name, report_count, $time, want, got);
            end
        end
    endfunction

    always @(posedge i_clk) begin
        t_console_report want;
        t_console_report got;
        if (!i_rst_n) begin
            fill_from_row(0, {RESET_ATTR, BLANK_CHAR});
            shadow_row   = 0;
            shadow_col   = 0;
            shadow_color = RESET_ATTR;
            shadow_shown = 1'b0;
            awaited_reports.delete();
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                report_count++;
                got.row       = m_axis_tdata[4:0];
                got.col       = m_axis_tdata[11:5];
                got.creg      = m_axis_tdata[27:12];
                got.cell_data = m_axis_tdata[43:28];
                if (awaited_reports.size() == 0) begin
                    error_count++;
                    if (error_count <= MAX_REPORTED) begin
                        $display("Unexpected report %0d at %0t: row %0d col %0d reg %0h cell %0h",
                                 report_count, $time, got.row, got.col, got.creg,
                                 got.cell_data);
                    end
                end else begin
                    want = awaited_reports.pop_front();
                    check_field("cursor_row", 16'(want.row), 16'(got.row));
                    check_field("cursor_col", 16'(want.col), 16'(got.col));
                    check_field("cursor_reg", want.creg, got.creg);
                    check_field("cell_data", want.cell_data, got.cell_data);
                end
            end
            if (i_cfg_we) begin
                if (i_cfg_index == CFG_TEXT_COLOR) begin
                    shadow_color = i_cfg_data;
                end else begin
                    shadow_shown = i_cfg_data[0];
                end
            end
            if (s_axis_tvalid && s_axis_tready) begin
                item_count++;
                awaited_reports.push_back(advance_console(s_axis_tuser, s_axis_tdata[7:0],
                                                          s_axis_tdata[15:8],
                                                          s_axis_tdata[20:16],
                                                          s_axis_tdata[27:21]));
            end
        end
        pending = awaited_reports.size();
    end

endmodule

>>> test/text_console_writer_test.sv
// Stimulus and verdict for text_console_writer: directed items, then random text, cell
// writes and reads, clears and scrolls under several color and cursor settings.
// Depends on tcw_pkg, text_console_writer and tcw_console_checker.
module text_console_writer_test;
    import tcw_pkg::*;

    localparam int SWEEP_CYCLES = 80 * 25;
    localparam int LONG_HOLD    = 64;

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata  = '0;
    logic [1:0]  s_axis_tuser  = OP_PUT_CHAR;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [47:0] m_axis_tdata;
    logic        i_cfg_we      = 1'b0;
    logic        i_cfg_index   = CFG_TEXT_COLOR;
    logic [7:0]  i_cfg_data    = '0;

    int error_count;
    int pending;
    int item_count;
    int report_count;
    int scroll_count;

    bit calm          = 1'b0;
    bit long_hold_req = 1'b0;
    int sent_items    = 0;
    int phase_count   = 0;

    text_console_writer DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    tcw_console_checker console_watch (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .o_error_count (error_count),
        .o_pending     (pending),
        .o_items       (item_count),
        .o_reports     (report_count),
        .o_scrolls     (scroll_count)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    initial begin
        #30_000_000;
        $display("Timeout with %0d reports outstanding", pending);
        $display("DONE: errors detected");
        $finish;
    end

    // report sink: random stalls, one long hold-off, none in the calm stretch
    initial begin
        bit hold_served;
        int stall;
        hold_served = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (long_hold_req && !hold_served && !calm) begin
                hold_served = 1'b1;
                m_axis_tready <= 1'b0;
                repeat (LONG_HOLD - 1) @(negedge i_clk);
            end else if (!calm && $urandom_range(0, 5) == 0) begin
                stall = $urandom_range(1, 3);
                m_axis_tready <= 1'b0;
                repeat (stall - 1) @(negedge i_clk);
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    task automatic offer_item(input logic [1:0] op, input logic [7:0] ch, input logic [7:0] at,
                              input logic [4:0] row, input logic [6:0] col);
        int gap;
        if (!calm && $urandom_range(0, 4) == 0) begin
            gap = $urandom_range(1, 3);
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {4'b0, col, row, at, ch};
        s_axis_tuser  <= op;
        do @(posedge i_clk); while (!s_axis_tready);
        @(negedge i_clk);
        sent_items++;
    endtask

    task automatic put_char(input logic [7:0] ch);
        offer_item(OP_PUT_CHAR, ch, 8'($urandom), 5'($urandom), 7'($urandom));
    endtask

    task automatic read_cell(input logic [4:0] row, input logic [6:0] col);
        offer_item(OP_READ_AT, 8'($urandom), 8'($urandom), row, col);
    endtask

    // drain, wait out any sweep, then load both registers
    task automatic settle_and_set(input logic [7:0] color, input logic shown);
        s_axis_tvalid <= 1'b0;
        wait (pending == 0);
        repeat (SWEEP_CYCLES + 16) @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= CFG_TEXT_COLOR;
        i_cfg_data  <= color;
        @(negedge i_clk);
        i_cfg_index <= CFG_CURSOR_SHOWN;
        i_cfg_data  <= {7'b0, shown};
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        phase_count++;
    endtask

    task automatic random_phase(input int quota);
        int         start;
        int         k;
        int         len;
        bit         full;
        logic [1:0] op;
        logic [4:0] row;
        logic [6:0] col;
        start = sent_items;
        while (sent_items - start < quota) begin
            k = $urandom_range(0, 99);
            if (k < 55) begin
                len = ($urandom_range(0, 7) == 0) ? $urandom_range(70, 90)
                                                  : $urandom_range(0, 12);
                repeat (len) put_char(8'($urandom));
                if ($urandom_range(0, 3) != 0) begin
                    put_char(NEWLINE_CHAR);
                end
            end else if (k < 85) begin
                full = ($urandom_range(0, 7) == 0);
                row  = full ? 5'($urandom) : 5'($urandom_range(0, 24));
                col  = full ? 7'($urandom) : 7'($urandom_range(0, 79));
                op   = (k < 70) ? OP_WRITE_AT : OP_READ_AT;
                offer_item(op, 8'($urandom), 8'($urandom), row, col);
                if (op == OP_WRITE_AT && $urandom_range(0, 1) == 1) begin
                    read_cell(row, col);
                end
            end else if (k < 98) begin
                repeat ($urandom_range(1, 10)) put_char(NEWLINE_CHAR);
            end else begin
                offer_item(OP_CLEAR, 8'($urandom), 8'($urandom), 5'($urandom), 7'($urandom));
            end
        end
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        read_cell(5'd0, 7'd0);
        put_char(8'h41);
        put_char(8'h00);
        put_char(8'hFF);
        put_char(NEWLINE_CHAR);
        offer_item(OP_WRITE_AT, 8'hFF, 8'hFF, 5'd0, 7'd0);
        offer_item(OP_WRITE_AT, 8'h00, 8'h00, 5'd24, 7'd79);
        offer_item(OP_WRITE_AT, 8'h55, 8'hAA, 5'd25, 7'd0);
        offer_item(OP_WRITE_AT, 8'hAA, 8'h55, 5'd0, 7'd80);
        offer_item(OP_WRITE_AT, 8'h5A, 8'hA5, 5'd31, 7'd127);
        read_cell(5'd0, 7'd0);
        read_cell(5'd0, 7'd1);
        read_cell(5'd0, 7'd2);
        read_cell(5'd24, 7'd79);
        read_cell(5'd25, 7'd0);
        read_cell(5'd0, 7'd80);
        read_cell(5'd31, 7'd127);
        read_cell(5'd1, 7'd0);
        offer_item(OP_CLEAR, 8'hFF, 8'hFF, 5'd31, 7'd127);
        read_cell(5'd0, 7'd0);
        read_cell(5'd24, 7'd79);
        put_char(8'h7E);
        put_char(NEWLINE_CHAR);

        settle_and_set(8'hFF, 1'b1);
        random_phase(85);
        settle_and_set(8'h00, 1'b0);
        long_hold_req = 1'b1;
        random_phase(85);
        settle_and_set(8'($urandom), 1'b1);
        random_phase(85);
        settle_and_set(8'h1E, 1'b1);
        random_phase(85);
        calm = 1'b1;
        settle_and_set(8'($urandom), 1'b1);
        random_phase(60);

        s_axis_tvalid <= 1'b0;
        wait (pending == 0);
        repeat (SWEEP_CYCLES + 16) @(posedge i_clk);

        $display("Run covered %0d items and %0d reports, %0d of them after a scroll sweep,",
                 item_count, report_count, scroll_count);
        $display("across %0d register settings with random stalls on both channels.",
                 phase_count + 1);
        if (error_count == 0 && pending == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("%0d mismatches, %0d reports never arrived", error_count, pending);
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
